// ----- rtl/core/fst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fst_pkg: shared types and constants for the fingerprint set table
// Beat layouts, operation and status codes, controller states and the
// configuration port geometry.
// ----------------------------------------------------------------------------
package fst_pkg;

    // Default number of 256-bit entries
    localparam int DEPTH_DEF = 16;

    // Key layout
    localparam int KEY_W = 256;

    // Configuration port geometry
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int LIMIT_W = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
    localparam logic [0:0] REG_ENTRY_LIMIT = 1'b0;

    // Operation codes (code 3 behaves as lookup)
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // Result status codes
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_CAPACITY  = 2'd1;
    localparam logic [1:0] STS_PRESENT   = 2'd2;
    localparam logic [1:0] STS_NOT_FOUND = 2'd3;

    // Request beat
    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] key_word0;
        logic [63:0] key_word1;
        logic [63:0] key_word2;
        logic [63:0] key_word3;
    } req_beat_t;

    // Response beat
    typedef struct packed {
        logic [1:0] status;
        logic       hit;
        logic [3:0] position;
        logic [4:0] entry_count;
    } rsp_beat_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } fsm_state_t;

endpackage

// ----- rtl/core/fst_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fst_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module fst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/fingerprint_set_table_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fingerprint_set_table_core: ordered, bounded set of 256-bit fingerprints
// Add / remove / lookup against a RAM-held key list, scanned one entry per
// cycle; remove closes the gap with a read-then-write shift pass.
// ----------------------------------------------------------------------------
// Add and lookup scan the held entries up to the count, stopping at a match;
// the result then waits for the registered RAM read and the response load;
// remove adds a shift pass over the entries above the matched position.
// One item at a time: the next item can be taken in the cycle after the
// result is loaded into the output register. Reset: count cleared,
// entry_limit set to 16; key RAM left undefined and needs no clearing pass.
module fingerprint_set_table_core #(
    parameter int DEPTH = fst_pkg::DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // request channel
    input  logic                        req_valid,
    output logic                        req_stall,
    input  fst_pkg::req_beat_t          req_beat,
    // response channel
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output fst_pkg::rsp_beat_t          rsp_beat,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fst_pkg::PADDR_W-1:0] paddr,
    input  logic [fst_pkg::PDATA_W-1:0] pwdata,
    output logic [fst_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Registers
    fst_pkg::fsm_state_t            state_reg, state_next;
    logic [1:0]                     op_reg, op_next;
    logic [fst_pkg::KEY_W-1:0]      key_reg, key_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [fst_pkg::LIMIT_W-1:0]    limit_reg;
    logic [CW-1:0]                  idx_reg, idx_next;
    logic                           pend_reg, pend_next;
    logic [AW-1:0]                  pend_idx_reg, pend_idx_next;
    logic [AW-1:0]                  pos_reg, pos_next;
    fst_pkg::rsp_beat_t             res_reg, res_next;
    logic                           rsp_valid_reg, rsp_valid_next;
    fst_pkg::rsp_beat_t             rsp_beat_reg, rsp_beat_next;

    // RAM signals
    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [fst_pkg::KEY_W-1:0]      ram_wdata;
    logic [AW-1:0]                  ram_raddr;
    logic [fst_pkg::KEY_W-1:0]      ram_rdata;

    logic                           cfg_wr;

    // Key store
    fst_ram #(
        .WIDTH (fst_pkg::KEY_W),
        .DEPTH (DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[fst_pkg::PADDR_W-1:2] == fst_pkg::REG_ENTRY_LIMIT)
                  ? fst_pkg::PDATA_W'(limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= fst_pkg::LIMIT_RESET;
        end
        else if (cfg_wr && paddr[fst_pkg::PADDR_W-1:2] == fst_pkg::REG_ENTRY_LIMIT)
        begin
            limit_reg <= pwdata[fst_pkg::LIMIT_W-1:0];
        end
    end

    // Handshake outputs
    assign req_stall = (state_reg != fst_pkg::S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_beat  = rsp_beat_reg;

    // Read address always follows the issue index
    assign ram_raddr = idx_reg[AW-1:0];

    // Next state and datapath
    always_comb
    begin
        logic          match;
        logic          f_hit;
        logic [AW-1:0] f_pos;
        logic          full;
        logic [1:0]    sts;

        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        pos_next       = pos_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_beat_next  = rsp_beat_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[AW-1:0];
        ram_wdata      = key_reg;

        match = pend_reg && (ram_rdata == key_reg);
        f_hit = match;
        f_pos = match ? pend_idx_reg : '0;
        full  = (32'(count_reg) >= 32'(limit_reg)) || (32'(count_reg) >= DEPTH);
        sts   = fst_pkg::STS_OK;

        // output register drains
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            fst_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req_beat.opcode;
                    key_next   = {req_beat.key_word0, req_beat.key_word1,
                                  req_beat.key_word2, req_beat.key_word3};
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    state_next = fst_pkg::S_SCAN;
                end
            end

            fst_pkg::S_SCAN:
            begin
                if (!match && idx_reg < count_reg)
                begin
                    // keep scanning: one read issued per cycle
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[AW-1:0];
                    idx_next      = idx_reg + 1'b1;
                end
                else
                begin
                    // scan finished, act on the operation
                    pend_next  = 1'b0;
                    state_next = fst_pkg::S_RESP;
                    case (op_reg)
                        fst_pkg::OP_ADD:
                        begin
                            if (full)
                            begin
                                sts = fst_pkg::STS_CAPACITY;
                            end
                            else if (f_hit)
                            begin
                                sts = fst_pkg::STS_PRESENT;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        fst_pkg::OP_REMOVE:
                        begin
                            if (!f_hit)
                            begin
                                sts = fst_pkg::STS_NOT_FOUND;
                            end
                            else
                            begin
                                pos_next   = f_pos;
                                idx_next   = CW'(f_pos) + 1'b1;
                                state_next = fst_pkg::S_SHIFT;
                            end
                        end
                        default:
                        begin
                            sts = f_hit ? fst_pkg::STS_OK : fst_pkg::STS_NOT_FOUND;
                        end
                    endcase
                    res_next.status      = sts;
                    res_next.hit         = f_hit;
                    res_next.position    = 4'(f_pos);
                    res_next.entry_count = 5'(count_next);
                end
            end

            fst_pkg::S_SHIFT:
            begin
                // write back the entry read last cycle one place lower
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_idx_reg;
                    ram_wdata = ram_rdata;
                end
                if (idx_reg < count_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = AW'(idx_reg - 1'b1);
                    idx_next      = idx_reg + 1'b1;
                end
                else
                begin
                    pend_next            = 1'b0;
                    count_next           = count_reg - 1'b1;
                    res_next.status      = fst_pkg::STS_OK;
                    res_next.hit         = 1'b1;
                    res_next.position    = 4'(pos_reg);
                    res_next.entry_count = 5'(count_reg - 1'b1);
                    state_next           = fst_pkg::S_RESP;
                end
            end

            fst_pkg::S_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_beat_next  = res_reg;
                    state_next     = fst_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = fst_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fst_pkg::S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        idx_reg      <= idx_next;
        pend_idx_reg <= pend_idx_next;
        pos_reg      <= pos_next;
        res_reg      <= res_next;
        rsp_beat_reg <= rsp_beat_next;
    end

endmodule

// ----- rtl/core/fst_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fst_checker: port-level checks for the fingerprint set table
// Response hold, one-item-at-a-time intake and result field consistency.
// ----------------------------------------------------------------------------
module fst_checker #(
    parameter int DEPTH = fst_pkg::DEPTH_DEF
) (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input fst_pkg::rsp_beat_t rsp_beat
);

    // Stalled response beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_beat))
        else $error("response beat changed while stalled");

    // An accepted request blocks intake on the next cycle
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second request taken while one is in flight");

    // Duplicate status implies a hit
    a_present_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_beat.status == fst_pkg::STS_PRESENT |-> rsp_beat.hit)
        else $error("already-present status without hit");

    // Miss reports position zero
    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_beat.hit |-> rsp_beat.position == 4'd0)
        else $error("nonzero position on a miss");

    // Count never exceeds depth
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 32'(rsp_beat.entry_count) <= DEPTH)
        else $error("entry count above depth");

endmodule

bind fingerprint_set_table_core fst_checker #(.DEPTH(DEPTH)) u_fst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_beat  (rsp_beat)
);
